### src/u8vd_pkg.sv
// Types and constants shared by the UTF-8 validating decoder.
`default_nettype none

package u8vd_pkg;

  // Command codes of an input beat.
  localparam logic CmdData = 1'b0;
  localparam logic CmdEnd  = 1'b1;

  // Bad-sequence handling modes; the fourth code behaves as ModeReport.
  localparam logic [1:0] ModeReport  = 2'd0;
  localparam logic [1:0] ModeReplace = 2'd1;
  localparam logic [1:0] ModeDrop    = 2'd2;

  localparam logic [20:0] ReplacementChar = 21'h00FFFD;

  // Lead byte limits and the RFC 3629 second-byte limits.
  localparam logic [7:0] LeadMin     = 8'hC2;
  localparam logic [7:0] LeadMax     = 8'hF4;
  localparam logic [7:0] Lead3Min    = 8'hE0;
  localparam logic [7:0] Lead4Min    = 8'hF0;
  localparam logic [7:0] LeadE0      = 8'hE0;
  localparam logic [7:0] LeadED      = 8'hED;
  localparam logic [7:0] LeadF0      = 8'hF0;
  localparam logic [7:0] LeadF4      = 8'hF4;
  localparam logic [7:0] SecondE0Min = 8'hA0;
  localparam logic [7:0] SecondEDMax = 8'h9F;
  localparam logic [7:0] SecondF0Min = 8'h90;
  localparam logic [7:0] SecondF4Max = 8'h8F;
  localparam logic [7:0] ContMin     = 8'h80;
  localparam logic [7:0] ContMax     = 8'hBF;

  // Depth of the result queue and its pointer and count widths.
  localparam int unsigned FifoDepth = 4;
  localparam int unsigned PtrW      = $clog2(FifoDepth);
  localparam int unsigned CntW      = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    ST_CHAR = 2'd0,
    ST_REPL = 2'd1,
    ST_ERR  = 2'd2,
    ST_END  = 2'd3
  } status_e;

  typedef struct packed {
    logic       command;
    logic [7:0] data_byte;
  } in_item_t;

  typedef struct packed {
    logic [20:0] code_point;
    status_e     status;
    logic        last;
  } out_item_t;

endpackage

`default_nettype wire

### src/utf8_validating_decoder.sv
// UTF-8 validating decoder: input register, sequence logic and result queue.
// A beat is captured in the input register; its results are then written into the result
// queue, from which they are offered, and a full queue can hold the beat in the register.
// Throughput: one byte per cycle while the four-entry result queue holds at most two
// results; only then does a beat leave the input register, as one beat may cause two.
// Reset clears the pending sequence and the queue and sets mode_q to report.
`default_nettype none

module utf8_validating_decoder (
  input  wire                       clk_i,
  input  wire                       rst_ni,
  input  wire                       cfg_we_i,
  input  wire  [1:0]                cfg_wdata_i,
  input  wire                       in_valid_i,
  output logic                      in_stall_o,
  input  wire u8vd_pkg::in_item_t   in_data_i,
  output logic                      out_valid_o,
  input  wire                       out_stall_i,
  output u8vd_pkg::out_item_t       out_data_o
);

  logic [1:0] mode_q;

  // Input register.
  logic                 in_vld_q, in_vld_d;
  u8vd_pkg::in_item_t   in_q;
  logic                 in_accept;
  logic                 adv;

  // Sequence state.
  logic [7:0] lead_q, lead_d;
  logic [7:0] second_q, second_d;
  logic [7:0] third_q, third_d;
  logic [1:0] held_q, held_d;

  // Result queue.
  u8vd_pkg::out_item_t                  fifo_q [u8vd_pkg::FifoDepth];
  logic [u8vd_pkg::PtrW-1:0]            head_q, head_d;
  logic [u8vd_pkg::PtrW-1:0]            tail_q, tail_d;
  logic [u8vd_pkg::CntW-1:0]            cnt_q, cnt_d;
  logic                                 out_pop;

  u8vd_pkg::out_item_t res0, res1, bad_res;
  logic [1:0]          nres;
  logic                bad_emits;
  logic [7:0]          b;
  logic                valid_seq;
  logic [20:0]         seq_cp;
  logic                second_ok;
  logic [2:0]          seq_len;

  assign adv        = in_vld_q && (cnt_q <= u8vd_pkg::CntW'(u8vd_pkg::FifoDepth - 2));
  assign in_stall_o = in_vld_q && !adv;
  assign in_accept  = in_valid_i && !in_stall_o;
  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = fifo_q[head_q];
  assign out_pop     = out_valid_o && !out_stall_i;

  always_comb begin
    in_vld_d = in_vld_q;
    if (in_accept) begin
      in_vld_d = 1'b1;
    end else if (adv) begin
      in_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= u8vd_pkg::ModeReport;
      in_vld_q <= 1'b0;
      lead_q   <= '0;
      second_q <= '0;
      third_q  <= '0;
      held_q   <= '0;
      head_q   <= '0;
      tail_q   <= '0;
      cnt_q    <= '0;
    end else begin
      if (cfg_we_i) begin
        mode_q <= cfg_wdata_i;
      end
      in_vld_q <= in_vld_d;
      lead_q   <= lead_d;
      second_q <= second_d;
      third_q  <= third_d;
      held_q   <= held_d;
      head_q   <= head_d;
      tail_q   <= tail_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      in_q <= in_data_i;
    end
  end

  // Judging of a complete multi-byte sequence; b is its final byte.
  always_comb begin
    b = in_q.data_byte;
    if (lead_q >= u8vd_pkg::Lead4Min) begin
      seq_len = 3'd4;
    end else if (lead_q >= u8vd_pkg::Lead3Min) begin
      seq_len = 3'd3;
    end else begin
      seq_len = 3'd2;
    end

    second_ok = (second_q inside {[u8vd_pkg::ContMin:u8vd_pkg::ContMax]});
    if (lead_q == u8vd_pkg::LeadE0) begin
      second_ok = (second_q inside {[u8vd_pkg::SecondE0Min:u8vd_pkg::ContMax]});
    end else if (lead_q == u8vd_pkg::LeadED) begin
      second_ok = (second_q inside {[u8vd_pkg::ContMin:u8vd_pkg::SecondEDMax]});
    end else if (lead_q == u8vd_pkg::LeadF0) begin
      second_ok = (second_q inside {[u8vd_pkg::SecondF0Min:u8vd_pkg::ContMax]});
    end else if (lead_q == u8vd_pkg::LeadF4) begin
      second_ok = (second_q inside {[u8vd_pkg::ContMin:u8vd_pkg::SecondF4Max]});
    end

    case (seq_len)
      3'd2: begin
        valid_seq = (b[7:6] == 2'b10);
        seq_cp    = {10'd0, lead_q[4:0], b[5:0]};
      end
      3'd3: begin
        valid_seq = (b[7:6] == 2'b10) && second_ok;
        seq_cp    = {5'd0, lead_q[3:0], second_q[5:0], b[5:0]};
      end
      default: begin
        valid_seq = (b[7:6] == 2'b10) && (third_q[7:6] == 2'b10) && second_ok;
        seq_cp    = {lead_q[2:0], second_q[5:0], third_q[5:0], b[5:0]};
      end
    endcase
  end

  // Results and next sequence state for the beat in the input register.
  always_comb begin
    bad_emits = (mode_q != u8vd_pkg::ModeDrop);
    bad_res   = '{code_point: '0, status: u8vd_pkg::ST_ERR, last: 1'b0};
    if (mode_q == u8vd_pkg::ModeReplace) begin
      bad_res = '{code_point: u8vd_pkg::ReplacementChar, status: u8vd_pkg::ST_REPL,
                  last: 1'b0};
    end

    res0     = bad_res;
    res1     = '{code_point: '0, status: u8vd_pkg::ST_END, last: 1'b1};
    nres     = 2'd0;
    lead_d   = lead_q;
    second_d = second_q;
    third_d  = third_q;
    held_d   = held_q;

    if (adv) begin
      if (in_q.command == u8vd_pkg::CmdEnd) begin
        if (held_q != 2'd0 && bad_emits) begin
          nres = 2'd2;
        end else begin
          res0 = '{code_point: '0, status: u8vd_pkg::ST_END, last: 1'b0};
          nres = 2'd1;
        end
        lead_d   = '0;
        second_d = '0;
        third_d  = '0;
        held_d   = '0;
      end else if (held_q == 2'd0) begin
        if (!b[7]) begin
          res0 = '{code_point: {13'd0, b}, status: u8vd_pkg::ST_CHAR, last: 1'b0};
          nres = 2'd1;
        end else if (b inside {[u8vd_pkg::LeadMin:u8vd_pkg::LeadMax]}) begin
          lead_d = b;
          held_d = 2'd1;
        end else begin
          nres = {1'b0, bad_emits};
        end
      end else if ({1'b0, held_q} + 3'd1 < seq_len) begin
        if (held_q == 2'd1) begin
          second_d = b;
        end else begin
          third_d = b;
        end
        held_d = held_q + 2'd1;
      end else begin
        if (valid_seq) begin
          res0 = '{code_point: seq_cp, status: u8vd_pkg::ST_CHAR, last: 1'b0};
          nres = 2'd1;
        end else begin
          nres = {1'b0, bad_emits};
        end
        lead_d   = '0;
        second_d = '0;
        third_d  = '0;
        held_d   = '0;
      end
    end
    // The first result is the last one when it stands alone.
    res0.last = (nres == 2'd1);
  end

  // Result queue pointers.
  always_comb begin
    tail_d = tail_q + u8vd_pkg::PtrW'(nres);
    head_d = head_q + u8vd_pkg::PtrW'(out_pop);
    cnt_d  = cnt_q + u8vd_pkg::CntW'(nres) - u8vd_pkg::CntW'(out_pop);
  end

  always_ff @(posedge clk_i) begin
    if (nres != 2'd0) begin
      fifo_q[tail_q] <= res0;
    end
    if (nres == 2'd2) begin
      fifo_q[tail_q + u8vd_pkg::PtrW'(1)] <= res1;
    end
  end

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= u8vd_pkg::CntW'(u8vd_pkg::FifoDepth))
    else $error("result queue count beyond its depth");

  a_lead_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    held_q != 2'd0 |-> (lead_q >= u8vd_pkg::LeadMin && lead_q <= u8vd_pkg::LeadMax))
    else $error("pending sequence has an invalid lead byte");

  a_held_len: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (held_q != 2'd3 || lead_q >= u8vd_pkg::Lead4Min) &&
    (held_q != 2'd2 || lead_q >= u8vd_pkg::Lead3Min))
    else $error("more bytes held than the lead byte allows");

  a_end_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (adv && in_q.command == u8vd_pkg::CmdEnd) |=> (held_q == 2'd0))
    else $error("end marker did not clear the pending sequence");

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    nres != 2'd0 |-> cnt_q <= u8vd_pkg::CntW'(u8vd_pkg::FifoDepth - 2))
    else $error("results pushed without room in the queue");

endmodule

`default_nettype wire

### bench/u8vd_tb_pkg.sv
// Scoreboard for the UTF-8 validating decoder bench: expected results and their checks.
package u8vd_tb_pkg;
  import u8vd_pkg::*;

  class decode_scoreboard;
    logic [1:0]  mode;
    logic [7:0]  lead;
    logic [7:0]  second;
    logic [7:0]  third;
    logic [1:0]  held;
    out_item_t   expected_q[$];
    out_item_t   beat_q[$];
    int unsigned errors;

    function new();
      mode   = ModeReport;
      errors = 0;
      clear_seq();
    endfunction

    function void set_mode(logic [1:0] m);
      mode = m;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    function void clear_seq();
      lead   = '0;
      second = '0;
      third  = '0;
      held   = '0;
    endfunction

    function int seq_length(logic [7:0] l);
      if (l >= Lead4Min) return 4;
      if (l >= Lead3Min) return 3;
      return 2;
    endfunction

    function bit is_cont(logic [7:0] b);
      return b >= ContMin && b <= ContMax;
    endfunction

    function void add_result(logic [20:0] cp, status_e st);
      out_item_t r;
      r.code_point = cp;
      r.status     = st;
      r.last       = 1'b0;
      beat_q.push_back(r);
    endfunction

    function void add_bad();
      if (mode == ModeDrop) return;
      if (mode == ModeReplace) add_result(ReplacementChar, ST_REPL);
      else add_result('0, ST_ERR);
    endfunction

    // Judges a complete sequence whose final byte is fin.
    function bit judge(logic [7:0] fin, output logic [20:0] cp);
      bit second_ok;
      cp = '0;
      if (!is_cont(fin)) return 0;
      case (seq_length(lead))
        2: begin
          cp = {10'd0, lead[4:0], fin[5:0]};
          return 1;
        end
        3: begin
          if (lead == LeadE0) second_ok = second >= SecondE0Min && second <= ContMax;
          else if (lead == LeadED) second_ok = second >= ContMin && second <= SecondEDMax;
          else second_ok = is_cont(second);
          if (!second_ok) return 0;
          cp = {5'd0, lead[3:0], second[5:0], fin[5:0]};
          return 1;
        end
        default: begin
          if (!is_cont(third)) return 0;
          if (lead == LeadF0) second_ok = second >= SecondF0Min && second <= ContMax;
          else if (lead == LeadF4) second_ok = second >= ContMin && second <= SecondF4Max;
          else second_ok = is_cont(second);
          if (!second_ok) return 0;
          cp = {lead[2:0], second[5:0], third[5:0], fin[5:0]};
          return 1;
        end
      endcase
    endfunction

    // Works out what an accepted input beat should produce.
    function void note_beat(in_item_t it);
      logic [20:0] cp;
      logic [7:0]  b;
      b = it.data_byte;
      beat_q.delete();
      if (it.command == CmdEnd) begin
        if (held != 0) add_bad();
        clear_seq();
        add_result('0, ST_END);
      end else if (held == 0) begin
        if (!b[7]) add_result({13'd0, b}, ST_CHAR);
        else if (b >= LeadMin && b <= LeadMax) begin
          lead = b;
          held = 2'd1;
        end else add_bad();
      end else if (int'(held) + 1 < seq_length(lead)) begin
        if (held == 2'd1) second = b;
        else third = b;
        held = held + 2'd1;
      end else begin
        if (held == 2'd1) second = b;
        if (judge(b, cp)) add_result(cp, ST_CHAR);
        else add_bad();
        clear_seq();
      end
      if (beat_q.size() > 0) beat_q[beat_q.size() - 1].last = 1'b1;
      foreach (beat_q[i]) expected_q.push_back(beat_q[i]);
    endfunction

    function void check_result(out_item_t got);
      out_item_t want;
      if (expected_q.size() == 0) begin
        $display("%0t: unexpected result code_point=%h status=%0d last=%0d",
                 $time, got.code_point, got.status, got.last);
        errors++;
        return;
      end
      want = expected_q.pop_front();
      if (got.code_point !== want.code_point) begin
        $display("%0t: code_point expected %h actual %h", $time, want.code_point,
                 got.code_point);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
        errors++;
      end
      if (got.last !== want.last) begin
        $display("%0t: last expected %0d actual %0d", $time, want.last, got.last);
        errors++;
      end
    endfunction
  endclass

endpackage

### bench/tb_utf8_validating_decoder.sv
// Bench for the UTF-8 validating decoder: directed and random byte streams under all modes.
module tb_utf8_validating_decoder;
  import u8vd_pkg::*;
  import u8vd_tb_pkg::*;

  localparam logic [1:0] ModeUndef = 2'd3;
  localparam int StallLimit = 2000;
  localparam int LongHold   = 60;
  localparam int PhaseBeats = 235;

  logic      clk;
  logic      rst_n     = 1'b0;
  logic      cfg_we    = 1'b0;
  logic [1:0] cfg_wdata = '0;
  logic      in_valid  = 1'b0;
  in_item_t  in_data   = '0;
  logic      out_stall = 1'b0;
  logic      in_stall;
  logic      out_valid;
  out_item_t out_data;

  decode_scoreboard board;
  in_item_t  plan_q[$];
  int        beats_in = 0;
  int        idle_cycles = 0;

  utf8_validating_decoder dut (
    .clk_i      (clk),
    .rst_ni     (rst_n),
    .cfg_we_i   (cfg_we),
    .cfg_wdata_i(cfg_wdata),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall),
    .in_data_i  (in_data),
    .out_valid_o(out_valid),
    .out_stall_i(out_stall),
    .out_data_o (out_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function void plan_byte(logic [7:0] b);
    in_item_t it;
    it.command   = CmdData;
    it.data_byte = b;
    plan_q.push_back(it);
  endfunction

  function void plan_end(logic [7:0] b);
    in_item_t it;
    it.command   = CmdEnd;
    it.data_byte = b;
    plan_q.push_back(it);
  endfunction

  function logic [7:0] legal_second(logic [7:0] l);
    case (l)
      LeadE0:  return 8'($urandom_range(SecondE0Min, ContMax));
      LeadED:  return 8'($urandom_range(ContMin, SecondEDMax));
      LeadF0:  return 8'($urandom_range(SecondF0Min, ContMax));
      LeadF4:  return 8'($urandom_range(ContMin, SecondF4Max));
      default: return 8'($urandom_range(ContMin, ContMax));
    endcase
  endfunction

  // Bytes near the continuation and second-byte limits, or anything at all.
  function logic [7:0] edgy_byte();
    logic [7:0] edges [10];
    edges = '{8'h00, 8'h7F, 8'h80, 8'h8F, 8'h90, 8'h9F, 8'hA0, 8'hBF, 8'hC0, 8'hFF};
    case ($urandom_range(0, 2))
      0:       return edges[$urandom_range(0, 9)];
      1:       return 8'($urandom_range(ContMin, ContMax));
      default: return 8'($urandom_range(0, 255));
    endcase
  endfunction

  function int length_of(logic [7:0] l);
    return (l >= Lead4Min) ? 4 : (l >= Lead3Min) ? 3 : 2;
  endfunction

  // Mostly well-formed sequences with random content; the rest is end markers, noise
  // and broken or truncated sequences.
  function void plan_sequence();
    int kind;
    int n;
    logic [7:0] l;
    kind = $urandom_range(0, 99);
    if (kind < 25) begin
      plan_byte(8'($urandom_range(0, 127)));
    end else if (kind < 70) begin
      n = $urandom_range(2, 4);
      if (n == 2) l = 8'($urandom_range(LeadMin, 8'hDF));
      else if (n == 3) begin
        if ($urandom_range(0, 3) == 0) l = $urandom_range(0, 1) ? LeadE0 : LeadED;
        else l = 8'($urandom_range(Lead3Min, 8'hEF));
      end else l = 8'($urandom_range(Lead4Min, LeadMax));
      plan_byte(l);
      plan_byte(n == 2 ? 8'($urandom_range(ContMin, ContMax)) : legal_second(l));
      for (int i = 2; i < n; i++) plan_byte(8'($urandom_range(ContMin, ContMax)));
    end else if (kind < 75) begin
      plan_end(8'($urandom_range(0, 255)));
    end else if (kind < 83) begin
      plan_byte($urandom_range(0, 1) ? 8'($urandom_range(ContMin, 8'hC1))
                                     : 8'($urandom_range(8'hF5, 8'hFF)));
    end else if (kind < 95) begin
      l = 8'($urandom_range(LeadMin, LeadMax));
      plan_byte(l);
      for (int i = 1; i < length_of(l); i++) plan_byte(edgy_byte());
    end else begin
      l = 8'($urandom_range(LeadMin, LeadMax));
      plan_byte(l);
      n = $urandom_range(0, length_of(l) - 2);
      for (int i = 0; i < n; i++) plan_byte(8'($urandom_range(ContMin, ContMax)));
      plan_end(8'($urandom_range(0, 255)));
    end
  endfunction

  // Holds the beat until the block takes it.
  task automatic send_beat(input in_item_t it);
    in_valid <= 1'b1;
    in_data  <= it;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_beat(it);
    beats_in++;
  endtask

  task automatic send_plan();
    int burst_left;
    int gap;
    burst_left = 0;
    while (plan_q.size() > 0) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        burst_left = $urandom_range(1, 30);
      end
      send_beat(plan_q.pop_front());
      burst_left--;
    end
    in_valid <= 1'b0;
  endtask

  // A beat that causes no result may still be in flight once the queue is empty.
  task automatic drain(input int extra);
    while (board.pending() != 0) @(posedge clk);
    repeat (extra) @(posedge clk);
  endtask

  task automatic write_mode(input logic [1:0] m);
    cfg_we    <= 1'b1;
    cfg_wdata <= m;
    @(posedge clk);
    board.set_mode(m);
    cfg_we <= 1'b0;
  endtask

  initial begin
    logic [1:0] phase_modes [6];
    board = new();
    phase_modes = '{ModeReplace, ModeDrop, ModeUndef, ModeReport, ModeDrop, ModeReplace};
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    write_mode(ModeReport);

    plan_byte(8'h00);
    plan_byte(8'h7F);
    plan_byte(8'hC1);
    plan_byte(8'hFF);
    plan_byte(8'hC2); plan_byte(8'h80);
    plan_byte(8'hE0); plan_byte(8'h9F); plan_byte(8'hBF);
    plan_byte(8'hED); plan_byte(8'hA0); plan_byte(8'h80);
    plan_byte(8'hF4); plan_byte(8'h8F); plan_byte(8'hBF); plan_byte(8'hBF);
    plan_byte(8'hF0); plan_byte(8'h8F); plan_byte(8'h80); plan_byte(8'h80);
    // A plain ASCII byte where a continuation belongs still completes the sequence.
    plan_byte(8'hC3); plan_byte(8'h41);
    plan_byte(8'hE1); plan_end(8'hFF);
    plan_end(8'hAA);
    send_plan();

    foreach (phase_modes[p]) begin
      drain(4);
      write_mode(phase_modes[p]);
      while (plan_q.size() < PhaseBeats) plan_sequence();
      send_plan();
    end

    drain(8);
    if (board.errors == 0) $display("ALL CHECKS PASSED");
    else $display("CHECKS FAILED");
    $finish;
  end

  // Receiver: a long hold once, otherwise runs of random stall patterns.
  initial begin
    int pattern;
    int span;
    bit hold_done;
    hold_done = 1'b0;
    wait (rst_n);
    forever begin
      if (!hold_done && beats_in >= 600) begin
        hold_done = 1'b1;
        repeat (LongHold) begin
          @(posedge clk);
          out_stall <= 1'b1;
        end
      end else begin
        pattern = $urandom_range(0, 3);
        span    = $urandom_range(4, 40);
        repeat (span) begin
          @(posedge clk);
          case (pattern)
            0:       out_stall <= 1'b0;
            1:       out_stall <= 1'($urandom_range(0, 1));
            2:       out_stall <= ~out_stall;
            default: out_stall <= ($urandom_range(0, 7) == 0);
          endcase
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) board.check_result(out_data);
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= StallLimit) begin
      $display("CHECKS FAILED");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

endmodule

### filelist.f
src/u8vd_pkg.sv
src/utf8_validating_decoder.sv
bench/u8vd_tb_pkg.sv
bench/tb_utf8_validating_decoder.sv
